@@ hw/rtl/emr_pkg.sv @@
package emr_pkg;

    // Samples that make up one group, and the widths that follow from it.
    localparam int GROUP_SIZE = 5;
    localparam int IDX_W      = $clog2(GROUP_SIZE);
    localparam int CNT_W      = $clog2(GROUP_SIZE + 1);

    // Distance scale: 1.715 in unsigned Q16.
    localparam int          SCALE_W   = 17;
    localparam logic [16:0] SCALE_Q16 = 17'd112394;
    localparam int          DUR_W     = 16;
    localparam int          PROD_W    = DUR_W + SCALE_W;
    localparam int          DIST_W    = PROD_W - 16;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port.
    localparam int ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_DEADBAND  = 3'd0,
        REG_HEARTBEAT = 3'd1,
        REG_MIN_DIST  = 3'd2,
        REG_MAX_DIST  = 3'd3,
        REG_ECHO_LIM  = 3'd4,
        REG_MIN_VALID = 3'd5
    } t_reg_idx;

    localparam logic [15:0] RST_DEADBAND  = 16'd200;
    localparam logic [31:0] RST_HEARTBEAT = 32'd300000;
    localparam logic [15:0] RST_MIN_DIST  = 16'd200;
    localparam logic [15:0] RST_MAX_DIST  = 16'd40000;
    localparam logic [15:0] RST_ECHO_LIM  = 16'd30000;
    localparam logic [2:0]  RST_MIN_VALID = 3'd3;

    // Send reasons.
    localparam logic [1:0] REASON_NONE      = 2'd0;
    localparam logic [1:0] REASON_FIRST     = 2'd1;
    localparam logic [1:0] REASON_CHANGE    = 2'd2;
    localparam logic [1:0] REASON_HEARTBEAT = 2'd3;

    typedef struct packed {
        logic [15:0] deadband_x100;
        logic [31:0] beat_period_ms;
        logic [15:0] min_distance_x100;
        logic [15:0] max_distance_x100;
        logic [15:0] echo_limit_us;
        logic [2:0]  min_valid;
    } t_cfg;

    // One classified sample handed from the front to the back.
    typedef struct packed {
        logic        good;
        logic [15:0] range_x100;
        logic [31:0] time_ms;
        logic        group_end;
    } t_qent;

endpackage

@@ hw/rtl/emr_regs.sv @@
module emr_regs import emr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;

    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Register writes complete in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.deadband_x100     <= RST_DEADBAND;
            r_cfg.beat_period_ms    <= RST_HEARTBEAT;
            r_cfg.min_distance_x100 <= RST_MIN_DIST;
            r_cfg.max_distance_x100 <= RST_MAX_DIST;
            r_cfg.echo_limit_us     <= RST_ECHO_LIM;
            r_cfg.min_valid         <= RST_MIN_VALID;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_DEADBAND:  r_cfg.deadband_x100     <= pwdata[15:0];
                REG_HEARTBEAT: r_cfg.beat_period_ms    <= pwdata;
                REG_MIN_DIST:  r_cfg.min_distance_x100 <= pwdata[15:0];
                REG_MAX_DIST:  r_cfg.max_distance_x100 <= pwdata[15:0];
                REG_ECHO_LIM:  r_cfg.echo_limit_us     <= pwdata[15:0];
                REG_MIN_VALID: r_cfg.min_valid         <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    // Read mux; unused addresses read as zero.
    always_comb begin
        case (w_idx)
            REG_DEADBAND:  prdata = {16'd0, r_cfg.deadband_x100};
            REG_HEARTBEAT: prdata = r_cfg.beat_period_ms;
            REG_MIN_DIST:  prdata = {16'd0, r_cfg.min_distance_x100};
            REG_MAX_DIST:  prdata = {16'd0, r_cfg.max_distance_x100};
            REG_ECHO_LIM:  prdata = {16'd0, r_cfg.echo_limit_us};
            REG_MIN_VALID: prdata = {29'd0, r_cfg.min_valid};
            default:       prdata = 32'd0;
        endcase
    end

endmodule

@@ hw/rtl/emr_front.sv @@
module emr_front import emr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_echo_duration_us,
    input  logic        i_echo_missing,
    input  logic [31:0] i_time_ms,
    input  t_cfg        i_cfg,
    output logic        o_push,
    output t_qent       o_push_data,
    input  logic        i_full
);

    typedef enum logic [1:0] {
        ST_TAKE,
        ST_SCALE,
        ST_CLASSIFY
    } t_state;

    t_state              r_state;
    logic [IDX_W-1:0]    r_pos;
    logic [15:0]         r_dur;
    logic                r_missing;
    logic [31:0]         r_time;
    logic                r_group_end;
    logic                r_in_limit;
    logic [DIST_W-1:0]   r_dist;
    logic [PROD_W-1:0]   w_product;
    logic                w_good;
    logic                w_pos_last;

    assign o_in_ready = (r_state == ST_TAKE);
    assign w_pos_last = (r_pos == IDX_W'(GROUP_SIZE - 1));

    // Duration to hundredths of a cm.
    assign w_product = PROD_W'(r_dur) * PROD_W'(SCALE_Q16);

    // A sample is good when the echo was in time and the distance is in the window.
    assign w_good = r_in_limit &&
                    (r_dist >= DIST_W'(i_cfg.min_distance_x100)) &&
                    (r_dist <= DIST_W'(i_cfg.max_distance_x100));

    assign o_push                 = (r_state == ST_CLASSIFY) && !i_full;
    assign o_push_data.good       = w_good;
    assign o_push_data.range_x100 = r_dist[15:0];
    assign o_push_data.time_ms    = r_time;
    assign o_push_data.group_end  = r_group_end;

    // Take, scale and classify one transaction at a time.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_TAKE;
            r_pos   <= '0;
        end else begin
            case (r_state)
                ST_TAKE: begin
                    if (i_in_valid) begin
                        r_dur       <= i_echo_duration_us;
                        r_missing   <= i_echo_missing;
                        r_time      <= i_time_ms;
                        r_group_end <= w_pos_last;
                        r_pos       <= w_pos_last ? '0 : r_pos + IDX_W'(1);
                        r_state     <= ST_SCALE;
                    end
                end
                ST_SCALE: begin
                    r_dist     <= w_product[PROD_W-1:16];
                    r_in_limit <= !r_missing && (r_dur <= i_cfg.echo_limit_us);
                    r_state    <= ST_CLASSIFY;
                end
                ST_CLASSIFY: begin
                    if (!i_full) begin
                        r_state <= ST_TAKE;
                    end
                end
                default: r_state <= ST_TAKE;
            endcase
        end
    end

endmodule

@@ hw/rtl/emr_queue.sv @@
module emr_queue import emr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_qent i_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_qent o_data
);

    t_qent             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              w_push;
    logic              w_pop;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rp <= (r_rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + QPTR_W'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ hw/rtl/emr_back.sv @@
module emr_back import emr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_q_valid,
    input  t_qent       i_q_data,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_distance_x100,
    output logic        o_reading_valid,
    output logic        o_send_now,
    output logic [1:0]  o_send_reason,
    output logic [15:0] o_change_x100,
    output logic [2:0]  o_good_count
);

    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_RANK,
        ST_DECIDE
    } t_state;

    t_state           r_state;
    logic [15:0]      r_store [GROUP_SIZE];
    logic [CNT_W-1:0] r_cnt;
    logic [IDX_W-1:0] r_idx;
    logic [15:0]      r_med;
    logic [31:0]      r_time;
    logic [15:0]      r_last_sent;
    logic             r_have_sent;
    logic [31:0]      r_stamp;
    logic             r_out_valid;
    logic [15:0]      r_distance;
    logic             r_reading_valid;
    logic [1:0]       r_reason;
    logic [15:0]      r_change;
    logic [2:0]       r_good_count;

    logic [CNT_W-1:0] n_cnt;
    logic             w_store_en;
    logic [15:0]      w_cand;
    logic [CNT_W-1:0] w_rank;
    logic [15:0]      w_diff;
    logic [15:0]      w_change;
    logic [31:0]      w_elapsed;
    logic [2:0]       w_need;
    logic             w_valid;
    logic [1:0]       w_reason;
    logic             w_out_free;
    logic             w_load;

    assign o_pop       = (r_state == ST_COLLECT) && i_q_valid;
    assign w_store_en  = o_pop && i_q_data.good && (r_cnt < CNT_W'(GROUP_SIZE));
    assign n_cnt       = w_store_en ? r_cnt + CNT_W'(1) : r_cnt;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_load      = (r_state == ST_DECIDE) && w_out_free;

    // Rank of the current candidate among the group's good samples, equal values
    // ordered by arrival so that exactly one entry holds each rank.
    always_comb begin
        w_cand = r_store[r_idx];
        w_rank = '0;
        for (int j = 0; j < GROUP_SIZE; j++) begin
            if (CNT_W'(j) < r_cnt) begin
                if (r_store[j] < w_cand) begin
                    w_rank = w_rank + CNT_W'(1);
                end else if ((r_store[j] == w_cand) && (IDX_W'(j) < r_idx)) begin
                    w_rank = w_rank + CNT_W'(1);
                end
            end
        end
    end

    // Send decision for a completed group.
    always_comb begin
        w_diff    = (r_med >= r_last_sent) ? r_med - r_last_sent : r_last_sent - r_med;
        w_change  = r_have_sent ? w_diff : 16'd0;
        w_elapsed = r_time - r_stamp;
        w_need    = (i_cfg.min_valid == 3'd0) ? 3'd1 : i_cfg.min_valid;
        w_valid   = (32'(r_cnt) >= 32'(w_need));
        if (!w_valid) begin
            w_reason = REASON_NONE;
        end else if (!r_have_sent) begin
            w_reason = REASON_FIRST;
        end else if (w_change >= i_cfg.deadband_x100) begin
            w_reason = REASON_CHANGE;
        end else if (w_elapsed >= i_cfg.beat_period_ms) begin
            w_reason = REASON_HEARTBEAT;
        end else begin
            w_reason = REASON_NONE;
        end
    end

    // Sample storage is plain payload; only entries written in the current group are read.
    always_ff @(posedge i_clk) begin
        if (w_store_en) begin
            r_store[r_cnt[IDX_W-1:0]] <= i_q_data.range_x100;
        end
    end

    // Group sequencer, send state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_COLLECT;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_have_sent <= 1'b0;
            r_last_sent <= '0;
            r_stamp     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && !w_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_COLLECT: begin
                    if (o_pop) begin
                        r_cnt <= n_cnt;
                        if (i_q_data.group_end) begin
                            r_time  <= i_q_data.time_ms;
                            r_idx   <= '0;
                            r_state <= ST_RANK;
                        end
                    end
                end
                ST_RANK: begin
                    if ((CNT_W'(r_idx) < r_cnt) && (w_rank == (r_cnt >> 1))) begin
                        r_med <= w_cand;
                    end
                    if (r_idx == IDX_W'(GROUP_SIZE - 1)) begin
                        r_state <= ST_DECIDE;
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                ST_DECIDE: begin
                    if (w_out_free) begin
                        r_out_valid     <= 1'b1;
                        r_reading_valid <= w_valid;
                        r_distance      <= w_valid ? r_med : 16'd0;
                        r_change        <= w_valid ? w_change : 16'd0;
                        r_reason        <= w_reason;
                        r_good_count    <= (32'(r_cnt) > 32'd7) ? 3'd7 : 3'(r_cnt);
                        if (w_reason != REASON_NONE) begin
                            r_have_sent <= 1'b1;
                            r_last_sent <= r_med;
                            r_stamp     <= r_time;
                        end
                        r_cnt   <= '0;
                        r_state <= ST_COLLECT;
                    end
                end
                default: r_state <= ST_COLLECT;
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_distance_x100 = r_distance;
    assign o_reading_valid = r_reading_valid;
    assign o_send_now      = (r_reason != REASON_NONE);
    assign o_send_reason   = r_reason;
    assign o_change_x100   = r_change;
    assign o_good_count    = r_good_count;

endmodule

@@ hw/rtl/echo_median_report_on_change.sv @@
// Echo median filter with send-on-change reporting. Each input transaction is one
// echo sample (duration in us, missing flag, ms timestamp). The front takes a
// transaction, scales the duration to hundredths of a cm by 112394/65536 and
// classifies it against the echo limit and the distance window in the steps accept,
// multiply and classify; o_in_ready stays low until the classified sample is pushed,
// so the front holds one sample at a time and, when nothing stalls, sets the sustained
// rate. A two-entry queue passes classified samples to the back, which stores good
// ones and, after every group of five samples, ranks each stored value in turn for
// the upper median and then makes the send decision before the result transaction
// is loaded into the output register. The front keeps accepting samples while a
// result waits to be taken, until the queue is full. The six configuration
// registers sit at byte addresses 0 to 20 in steps of 4 and are meant to be written
// while no group is in progress.
module echo_median_report_on_change import emr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [15:0]       i_echo_duration_us,
    input  logic              i_echo_missing,
    input  logic [31:0]       i_time_ms,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [15:0]       o_distance_x100,
    output logic              o_reading_valid,
    output logic              o_send_now,
    output logic [1:0]        o_send_reason,
    output logic [15:0]       o_change_x100,
    output logic [2:0]        o_good_count,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg  w_cfg;
    logic  w_push;
    t_qent w_push_data;
    logic  w_full;
    logic  w_pop;
    logic  w_q_valid;
    t_qent w_q_data;

    // Configuration registers.
    emr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Sample intake and classification.
    emr_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_echo_duration_us (i_echo_duration_us),
        .i_echo_missing     (i_echo_missing),
        .i_time_ms          (i_time_ms),
        .i_cfg              (w_cfg),
        .o_push             (w_push),
        .o_push_data        (w_push_data),
        .i_full             (w_full)
    );

    // Queue between the two halves.
    emr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    // Median, send decision and result register.
    emr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (w_cfg),
        .i_q_valid       (w_q_valid),
        .i_q_data        (w_q_data),
        .o_pop           (w_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_distance_x100 (o_distance_x100),
        .o_reading_valid (o_reading_valid),
        .o_send_now      (o_send_now),
        .o_send_reason   (o_send_reason),
        .o_change_x100   (o_change_x100),
        .o_good_count    (o_good_count)
    );

endmodule

@@ hw/rtl/emr_checker.sv @@
module emr_checker import emr_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [15:0] o_distance_x100,
    input logic        o_reading_valid,
    input logic        o_send_now,
    input logic [1:0]  o_send_reason,
    input logic [15:0] o_change_x100,
    input logic [2:0]  o_good_count
);

    // An invalid reading carries no distance, no change and no send.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_reading_valid) |->
            (o_distance_x100 == 16'd0) && (o_change_x100 == 16'd0) && !o_send_now)
        else $error("invalid reading carries data");

    // The send flag agrees with the reason code.
    a_send_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_send_now == (o_send_reason != REASON_NONE)))
        else $error("send flag and reason disagree");

    // A valid reading needs at least one good sample.
    a_valid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_reading_valid) |-> (o_good_count != 3'd0))
        else $error("valid reading without good samples");

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_distance_x100) && $stable(o_send_reason) &&
             $stable(o_change_x100) && $stable(o_good_count)))
        else $error("stalled result changed");

    // No result right after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind echo_median_report_on_change emr_checker u_checker (.*);

@@ test/echo_median_report_on_change_chk.sv @@
// Watches the sample and reading channels and the register port, keeps its
// own copy of the filter state, and compares every reading taken from the block.
module echo_median_report_on_change_chk import emr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [15:0]       i_echo_duration_us,
    input  logic              i_echo_missing,
    input  logic [31:0]       i_time_ms,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [15:0]       i_distance_x100,
    input  logic              i_reading_valid,
    input  logic              i_send_now,
    input  logic [1:0]        i_send_reason,
    input  logic [15:0]       i_change_x100,
    input  logic [2:0]        i_good_count,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [31:0]       i_pwdata,
    input  logic              i_pready,
    output int                o_mismatches,
    output int                o_outstanding,
    output int                o_readings,
    output int                o_sends
);

    typedef struct packed {
        logic [15:0] median_x100;
        logic        reading_valid;
        logic        send_now;
        logic [1:0]  send_reason;
        logic [15:0] change_x100;
        logic [2:0]  good_count;
    } t_reading;

    // Shadow copy of the registers and of the filter state.
    t_cfg        cfg;
    logic [15:0] stored [GROUP_SIZE];
    int          samples_in_group;
    int          good_in_group;
    logic [15:0] last_sent_x100;
    logic        sent_before;
    logic [31:0] last_sent_ms;
    t_reading    readings_due [$];

    // Upper median of the good distances collected in the current group.
    function automatic logic [15:0] upper_median(input int n);
        logic [15:0] v [GROUP_SIZE];
        logic [15:0] x;
        int          j;
        for (int i = 0; i < GROUP_SIZE; i++) v[i] = stored[i];
        for (int i = 1; i < n; i++) begin
            x = v[i];
            j = i;
            while (j > 0 && v[j-1] > x) begin
                v[j] = v[j-1];
                j--;
            end
            v[j] = x;
        end
        return v[n/2];
    endfunction

    // Classifies one sample; returns 1 with the reading when it closes a group.
    function automatic bit classify_sample(input logic [15:0] dur, input logic missing,
                                           input logic [31:0] stamp, output t_reading rd);
        logic [32:0] product;
        logic [16:0] scaled_x100;
        logic [15:0] median;
        logic [15:0] change;
        logic [1:0]  reason;
        logic [31:0] elapsed;
        int          need;
        rd = '0;
        if (!missing && dur <= cfg.echo_limit_us) begin
            product = dur * SCALE_Q16;
            scaled_x100 = product[32:16];
            if (scaled_x100 >= cfg.min_distance_x100 &&
                scaled_x100 <= cfg.max_distance_x100 &&
                good_in_group < GROUP_SIZE) begin
                stored[good_in_group] = scaled_x100[15:0];
                good_in_group++;
            end
        end
        samples_in_group++;
        if (samples_in_group < GROUP_SIZE) return 0;

        // A zero threshold behaves as one, so an empty group never counts.
        need = (cfg.min_valid == 0) ? 1 : int'(cfg.min_valid);
        rd.good_count = (good_in_group > 7) ? 3'd7 : 3'(good_in_group);
        if (good_in_group >= need) begin
            median = upper_median(good_in_group);
            change = '0;
            reason = REASON_NONE;
            if (sent_before)
                change = (median >= last_sent_x100) ? median - last_sent_x100
                                                    : last_sent_x100 - median;
            elapsed = stamp - last_sent_ms;
            if (!sent_before)
                reason = REASON_FIRST;
            else if (change >= cfg.deadband_x100)
                reason = REASON_CHANGE;
            else if (elapsed >= cfg.beat_period_ms)
                reason = REASON_HEARTBEAT;
            if (reason != REASON_NONE) begin
                last_sent_x100 = median;
                sent_before = 1'b1;
                last_sent_ms = stamp;
            end
            rd.median_x100 = median;
            rd.reading_valid = 1'b1;
            rd.send_now = (reason != REASON_NONE);
            rd.send_reason = reason;
            rd.change_x100 = change;
        end
        samples_in_group = 0;
        good_in_group = 0;
        return 1;
    endfunction

    // Register writes, result comparison and prediction, all on the rising edge.
    always @(posedge i_clk) begin
        t_reading fresh;
        t_reading got;
        t_reading want;
        if (!i_rst_n) begin
            cfg.deadband_x100 = RST_DEADBAND;
            cfg.beat_period_ms = RST_HEARTBEAT;
            cfg.min_distance_x100 = RST_MIN_DIST;
            cfg.max_distance_x100 = RST_MAX_DIST;
            cfg.echo_limit_us = RST_ECHO_LIM;
            cfg.min_valid = RST_MIN_VALID;
            samples_in_group = 0;
            good_in_group = 0;
            last_sent_x100 = '0;
            sent_before = 1'b0;
            last_sent_ms = '0;
            readings_due.delete();
            o_mismatches = 0;
            o_readings = 0;
            o_sends = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[ADDR_W-1:2]))
                    REG_DEADBAND:  cfg.deadband_x100 = i_pwdata[15:0];
                    REG_HEARTBEAT: cfg.beat_period_ms = i_pwdata;
                    REG_MIN_DIST:  cfg.min_distance_x100 = i_pwdata[15:0];
                    REG_MAX_DIST:  cfg.max_distance_x100 = i_pwdata[15:0];
                    REG_ECHO_LIM:  cfg.echo_limit_us = i_pwdata[15:0];
                    REG_MIN_VALID: cfg.min_valid = i_pwdata[2:0];
                    default: ;
                endcase
            end

            // Readings leave before new samples are classified in the same cycle.
            if (i_out_valid && i_out_ready) begin
                got = {i_distance_x100, i_reading_valid, i_send_now, i_send_reason,
                       i_change_x100, i_good_count};
                if (readings_due.size() == 0) begin
                    if (o_mismatches < 10)
                        $display("%0t: reading with none outstanding: dist %0d valid %0b",
                                 $time, got.median_x100, got.reading_valid);
                    o_mismatches++;
                end else begin
                    want = readings_due.pop_front();
                    o_readings++;
                    if (got !== want) begin
                        if (o_mismatches < 10) begin
                            $display("%0t: expected dist %0d valid %0b send %0b reason %0d",
                                     $time, want.median_x100, want.reading_valid,
                                     want.send_now, want.send_reason);
                            $display("    change %0d good %0d; got dist %0d valid %0b",
                                     want.change_x100, want.good_count,
                                     got.median_x100, got.reading_valid);
                            $display("    send %0b reason %0d change %0d good %0d",
                                     got.send_now, got.send_reason, got.change_x100,
                                     got.good_count);
                        end
                        o_mismatches++;
                    end
                end
            end

            if (i_in_valid && i_in_ready) begin
                if (classify_sample(i_echo_duration_us, i_echo_missing, i_time_ms, fresh)) begin
                    readings_due.push_back(fresh);
                    if (fresh.send_now) o_sends++;
                end
            end
        end
        o_outstanding = readings_due.size();
    end

endmodule

@@ test/echo_median_report_on_change_tb.sv @@
module echo_median_report_on_change_tb;
    import emr_pkg::*;

    localparam int ITEM_GOAL  = 1120;
    localparam int SETTLE_CYC = 30;
    localparam int RUN_LIMIT  = 5000000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [15:0]       i_echo_duration_us;
    logic              i_echo_missing;
    logic [31:0]       i_time_ms;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [15:0]       o_distance_x100;
    logic              o_reading_valid;
    logic              o_send_now;
    logic [1:0]        o_send_reason;
    logic [15:0]       o_change_x100;
    logic [2:0]        o_good_count;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    int          mismatches;
    int          outstanding;
    int          readings;
    int          sends;
    int          items_fed;
    int          settings_used;
    int          in_gap_pct;
    int          out_stall_pct;
    int          base_dist;
    logic [31:0] now_ms;
    t_cfg        cur_cfg;

    echo_median_report_on_change dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_echo_duration_us (i_echo_duration_us),
        .i_echo_missing     (i_echo_missing),
        .i_time_ms          (i_time_ms),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_distance_x100    (o_distance_x100),
        .o_reading_valid    (o_reading_valid),
        .o_send_now         (o_send_now),
        .o_send_reason      (o_send_reason),
        .o_change_x100      (o_change_x100),
        .o_good_count       (o_good_count),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    echo_median_report_on_change_chk reading_chk (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .i_in_ready         (o_in_ready),
        .i_echo_duration_us (i_echo_duration_us),
        .i_echo_missing     (i_echo_missing),
        .i_time_ms          (i_time_ms),
        .i_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .i_distance_x100    (o_distance_x100),
        .i_reading_valid    (o_reading_valid),
        .i_send_now         (o_send_now),
        .i_send_reason      (o_send_reason),
        .i_change_x100      (o_change_x100),
        .i_good_count       (o_good_count),
        .i_psel             (psel),
        .i_penable          (penable),
        .i_pwrite           (pwrite),
        .i_paddr            (paddr),
        .i_pwdata           (pwdata),
        .i_pready           (pready),
        .o_mismatches       (mismatches),
        .o_outstanding      (outstanding),
        .o_readings         (readings),
        .o_sends            (sends)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #RUN_LIMIT;
        $display("[echo_median_report_on_change] ERROR");
        $finish;
    end

    // Idle length: none with probability 100-pct, otherwise mostly short.
    function automatic int idle_len(input int pct);
        int r;
        r = $urandom_range(0, 99);
        if (r >= pct) return 0;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 15;
            2: return 40;
            default: return 75;
        endcase
    endfunction

    function automatic int clip(input int v, input int lo, input int hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    // Shortest echo whose scaled distance reaches the target.
    function automatic logic [15:0] to_duration(input int target);
        longint d;
        d = (longint'(clip(target, 0, 65535)) * 65536 + 112393) / 112394;
        return 16'(clip(int'(d), 0, 65535));
    endfunction

    function automatic t_cfg make_cfg(input int db, input logic [31:0] hb, input int mn,
                                      input int mx, input int lim, input int mv);
        t_cfg c;
        c.deadband_x100 = 16'(db);
        c.beat_period_ms = hb;
        c.min_distance_x100 = 16'(mn);
        c.max_distance_x100 = 16'(mx);
        c.echo_limit_us = 16'(lim);
        c.min_valid = 3'(mv);
        return c;
    endfunction

    // Mostly sensible settings, with the extremes of every register mixed in.
    function automatic t_cfg random_cfg();
        int          r;
        int          db;
        int          lo;
        int          hi;
        int          lim;
        int          mv;
        logic [31:0] hb;
        r = $urandom_range(0, 99);
        db = (r < 12) ? 0 : (r < 20) ? 40000 : $urandom_range(0, 500);
        r = $urandom_range(0, 99);
        hb = (r < 10) ? 32'd1 : (r < 20) ? 32'hFFFF_FFFF : (r < 30) ? $urandom
                                                        : $urandom_range(100, 3000);
        r = $urandom_range(0, 99);
        if (r < 10) begin
            lo = 0;
            hi = $urandom_range(0, 65535);
        end else if (r < 15) begin
            lo = $urandom_range(0, 40000);
            hi = lo;
        end else if (r < 20) begin
            lo = $urandom_range(1, 40000);
            hi = $urandom_range(0, lo - 1);
        end else begin
            lo = $urandom_range(0, 20000);
            hi = $urandom_range(lo, 45000);
        end
        r = $urandom_range(0, 99);
        lim = (r < 10) ? 65535 : (r < 15) ? 0 : (r < 25) ? $urandom_range(0, 65535)
                                                        : $urandom_range(15000, 40000);
        r = $urandom_range(0, 99);
        mv = (r < 5) ? 0 : (r < 10) ? $urandom_range(6, 7) : $urandom_range(1, 5);
        return make_cfg(db, hb, lo, hi, lim, mv);
    endfunction

    // One register write: setup cycle, then access cycle until pready.
    task automatic reg_write(input t_reg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_cfg(input t_cfg c);
        cur_cfg = c;
        reg_write(REG_DEADBAND, 32'(c.deadband_x100));
        reg_write(REG_HEARTBEAT, c.beat_period_ms);
        reg_write(REG_MIN_DIST, 32'(c.min_distance_x100));
        reg_write(REG_MAX_DIST, 32'(c.max_distance_x100));
        reg_write(REG_ECHO_LIM, 32'(c.echo_limit_us));
        reg_write(REG_MIN_VALID, 32'(c.min_valid));
        settings_used++;
    endtask

    // Offers one sample transaction and holds it until it is taken.
    task automatic feed(input logic [15:0] dur, input logic missing, input logic [31:0] stamp);
        int gap;
        i_in_valid         <= 1'b1;
        i_echo_duration_us <= dur;
        i_echo_missing     <= missing;
        i_time_ms          <= stamp;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_fed++;
        gap = idle_len(in_gap_pct);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Lets every reading drain and the back end go quiet.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    // One group of samples: mostly well-formed echoes around a base distance,
    // with missing echoes, overlong echoes and window edges mixed in.
    task automatic run_group();
        int          lo;
        int          hi;
        int          r;
        int          target;
        logic [15:0] dur;
        logic        missing;
        lo = cur_cfg.min_distance_x100;
        hi = cur_cfg.max_distance_x100;
        if (lo > hi) begin
            r = lo;
            lo = hi;
            hi = r;
        end
        r = $urandom_range(0, 99);
        if (r < 10)
            now_ms = now_ms + $urandom;
        else if (r < 25)
            now_ms = now_ms + cur_cfg.beat_period_ms - 300;
        if (r >= 55 || base_dist < lo || base_dist > hi)
            base_dist = $urandom_range(lo, hi);
        else
            base_dist = clip(base_dist + $urandom_range(0, 400) - 200, lo, hi);
        for (int k = 0; k < GROUP_SIZE; k++) begin
            now_ms = now_ms + $urandom_range(20, 80);
            missing = 1'b0;
            r = $urandom_range(0, 99);
            if (r < 70) begin
                target = base_dist + $urandom_range(0, 60) - 30;
                dur = to_duration(target);
            end else if (r < 78) begin
                missing = 1'b1;
                dur = $urandom_range(0, 65535);
            end else if (r < 86) begin
                dur = $urandom_range(0, 65535);
            end else if (r < 93) begin
                dur = 16'(clip(int'(cur_cfg.echo_limit_us) + $urandom_range(0, 2) - 1, 0, 65535));
            end else begin
                target = $urandom_range(0, 1) ? lo : hi;
                dur = 16'(clip(int'(to_duration(target)) + $urandom_range(0, 2) - 1, 0, 65535));
            end
            feed(dur, missing, now_ms);
        end
    endtask

    // Result side: the sink stalls at random, at a rate chosen per phase.
    initial begin
        int stall;
        i_out_ready = 1'b0;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                stall--;
            end else begin
                i_out_ready <= 1'b1;
                stall = idle_len(out_stall_pct);
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_echo_duration_us = '0;
        i_echo_missing = 1'b0;
        i_time_ms = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        items_fed = 0;
        settings_used = 0;
        in_gap_pct = 30;
        out_stall_pct = 30;
        base_dist = 5000;
        now_ms = 32'd1000;
        cur_cfg = make_cfg(RST_DEADBAND, RST_HEARTBEAT, RST_MIN_DIST, RST_MAX_DIST,
                           RST_ECHO_LIM, RST_MIN_VALID);
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings. Only one good sample: the others are too close, too
        // long, beyond the distance window or missing, so the group is invalid.
        feed(16'd0, 1'b0, 32'd0);
        feed(16'hFFFF, 1'b0, 32'd1);
        feed(16'd30000, 1'b0, 32'd2);
        feed(16'd1000, 1'b1, 32'd3);
        feed(16'd5000, 1'b0, 32'd4);
        // Five good samples out of order: the first reading is sent.
        feed(16'd1000, 1'b0, 32'hFFFF_FFEC);
        feed(16'd3000, 1'b0, 32'hFFFF_FFED);
        feed(16'd2000, 1'b0, 32'hFFFF_FFEE);
        feed(16'd5000, 1'b0, 32'hFFFF_FFEF);
        feed(16'd4000, 1'b0, 32'hFFFF_FFF0);
        // Same median just after the timestamp wraps: no send.
        feed(16'd4000, 1'b0, 32'd1);
        feed(16'd2000, 1'b0, 32'd2);
        feed(16'd3000, 1'b0, 32'd3);
        feed(16'd1000, 1'b0, 32'd4);
        feed(16'd5000, 1'b0, 32'd5);
        // Four good samples, one just under the minimum; the elapsed time
        // across the wrap equals the heartbeat exactly.
        feed(16'd1000, 1'b0, 32'd299980);
        feed(16'd2000, 1'b0, 32'd299981);
        feed(16'd116, 1'b0, 32'd299982);
        feed(16'd3000, 1'b0, 32'd299983);
        feed(16'd4000, 1'b0, 32'd299984);
        // Minimum and maximum distance edges, then a large change.
        feed(16'd117, 1'b0, 32'd299986);
        feed(16'd20000, 1'b0, 32'd299987);
        feed(16'd23000, 1'b0, 32'd299988);
        feed(16'd23324, 1'b0, 32'd299989);
        feed(16'd23325, 1'b0, 32'd299990);
        now_ms = 32'd300000;

        // Register extremes: wide open, zero-only window, empty group with a
        // zero threshold, empty window, threshold above the group size.
        for (int p = 0; p < 5; p++) begin
            settle();
            case (p)
                0: apply_cfg(make_cfg(0, 32'd1, 0, 65535, 65535, 1));
                1: apply_cfg(make_cfg(40000, 32'hFFFF_FFFF, 0, 0, 65535, 5));
                2: apply_cfg(make_cfg(40000, 32'hFFFF_FFFF, 40000, 40000, 0, 0));
                3: apply_cfg(make_cfg(100, 32'd500, 30000, 100, 30000, 7));
                default: apply_cfg(make_cfg(200, 32'd2000, 200, 40000, 30000, 6));
            endcase
            in_gap_pct = (p == 1) ? 0 : pick_pct();
            out_stall_pct = (p == 1) ? 0 : pick_pct();
            repeat (3) run_group();
        end

        // Random settings, each followed by a run of groups.
        while (items_fed < ITEM_GOAL) begin
            settle();
            apply_cfg(random_cfg());
            in_gap_pct = pick_pct();
            out_stall_pct = pick_pct();
            repeat ($urandom_range(2, 10)) run_group();
        end

        settle();
        $display("Fed %0d echo samples under %0d register settings.", items_fed, settings_used);
        $display("Checked %0d readings, %0d of them reported for sending.", readings, sends);
        if (mismatches == 0 && outstanding == 0) begin
            $display("[echo_median_report_on_change] OK");
        end else begin
            $display("[echo_median_report_on_change] ERROR");
        end
        $finish;
    end

endmodule
